FILE: rtl/tspam_pkg.sv
package tspam_pkg;

  localparam int MAX_CITIES_DEF = 256;
  localparam int COORD_BITS_DEF = 16;

  localparam int MODE_W  = 2;
  localparam int POS_W   = 8;
  localparam int COORD_W = 16;
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 34;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 9;
  localparam int TAG_W   = 2;
  localparam int LANES   = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd131;
  localparam logic [LEN_W-1:0]   LEN_MAX     = 34'h3_FFFF_FFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    MV_SWAP    = 2'd0,
    MV_REVERSE = 2'd1,
    MV_FRONT   = 2'd2,
    MV_ROTATE  = 2'd3
  } move_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

endpackage

FILE: rtl/tsp_annealing_move_engine.sv
// Move engine for simulated annealing on a closed tour. The host loads city coordinates
// (mode 0), proposes moves (mode 1) and reads tour entries (mode 2); every input word gives
// exactly one result word. A move rebuilds the whole tour into the spare half of a two-bank
// tour memory while both the current and the proposed tour lengths are measured, then the
// bank pointer flips if the move is kept, so a rejected move costs no restore. After reset
// the block runs a clearing pass that writes the identity tour, and accepts no input word
// until it is done. During a move one tour position is swept per cycle through the tour
// memory read ports, followed by the drain of the pipelined square-root unit that holds
// one stage per root bit. A new input word is taken while the previous result still waits
// in the output register.
module tsp_annealing_move_engine import tspam_pkg::*; #(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [POS_W-1:0]   city_index_i,
  input  logic [COORD_W-1:0] coord_x_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic [KIND_W-1:0]  move_kind_i,
  input  logic [POS_W-1:0]   first_pos_i,
  input  logic [POS_W-1:0]   second_pos_i,
  input  logic [LEN_W-1:0]   accept_margin_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEN_W-1:0]   old_length_o,
  output logic [LEN_W-1:0]   new_length_o,
  output logic               accepted_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [POS_W-1:0]   tour_entry_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int IW    = $clog2(MAX_CITIES);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int AW    = NW + 1;
  localparam int PCW   = (AW > POS_W) ? AW : POS_W;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int VAL_W = SQ_W + 1;
  localparam int RW    = (VAL_W + 17) / 2;
  localparam int SUM_W = RW + NW;
  localparam int CMP_W = ((SUM_W > LEN_W) ? SUM_W : LEN_W) + 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DECIDE,
    S_READ,
    S_RESULT
  } state_e;

  function automatic logic [COORD_BITS-1:0] abs_diff(logic [COORD_BITS-1:0] a,
                                                     logic [COORD_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [LEN_W-1:0] saturate(logic [SUM_W-1:0] s);
    return (CMP_W'(s) > CMP_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(s);
  endfunction

  // Control and move registers.
  state_e             state_q;
  logic [NW-1:0]      cnt_q;
  logic               cur_q;
  logic [COUNT_W-1:0] count_q;
  move_e              kind_q;
  logic [AW-1:0]      pa_q, pb_q, lo_q, hi_q, rot_a_q, rot_b_q;
  logic               bad_q;
  logic               idx_ok_q;
  logic [LEN_W-1:0]   margin_q;
  logic [SUM_W-1:0]   sum_old_q, sum_new_q;

  // Result staging and output register.
  logic [LEN_W-1:0]   res_old_q, res_new_q;
  logic               res_acc_q;
  status_e            res_status_q;
  logic [POS_W-1:0]   res_entry_q;
  logic               out_valid_q;
  logic [LEN_W-1:0]   out_old_q, out_new_q;
  logic               out_acc_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [POS_W-1:0]   out_entry_q;

  // Memories: coordinates and a two-bank tour.
  logic [COORD_BITS-1:0] x_mem [MAX_CITIES];
  logic [COORD_BITS-1:0] y_mem [MAX_CITIES];
  logic [IW-1:0]         tour_mem [2 * MAX_CITIES];

  // Sweep pipeline.
  logic                  s1_vld_q, s1_last_q, s2_vld_q, s2_last_q;
  logic [NW-1:0]         s1_i_q, s2_i_q;
  logic [IW-1:0]         tour_rd_a_q, tour_rd_b_q;
  logic [COORD_BITS-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [COORD_BITS-1:0] prev_ox_q, prev_oy_q, prev_nx_q, prev_ny_q;
  logic [COORD_BITS-1:0] first_ox_q, first_oy_q, first_nx_q, first_ny_q;
  logic [TAG_W-1:0]      s3_tag_q, s4_tag_q, s5_tag_q;
  logic [COORD_BITS-1:0] dxo_q, dyo_q, dxn_q, dyn_q;
  logic [SQ_W-1:0]       sxo_q, syo_q, sxn_q, syn_q;
  logic [LANES-1:0][VAL_W-1:0] s5_val_q;
  logic [TAG_W-1:0]            root_tag;
  logic [LANES-1:0][RW-1:0]    root_val;

  logic              in_acc;
  logic [NW-1:0]     n;
  logic              load_ok;
  logic [PCW-1:0]    pa_ext, pb_ext, n_ext;
  logic [AW-1:0]     pa_in, pb_in, lo_in, hi_in;
  logic [AW-1:0]     iw, src, j;
  logic [IW:0]       tour_ra, tour_rb, tour_wa;
  logic [IW-1:0]     tour_wd;
  logic              tour_we;
  logic              load_we;
  logic [COORD_BITS-1:0] cur_ox, cur_oy, cur_nx, cur_ny;
  logic              edge_vld;
  logic              take_out;
  logic              keep;

  assign in_stall  = (state_q != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Active city count, held to 3 .. MAX_CITIES.
  always_comb begin
    if (int'(count_q) > MAX_CITIES) begin
      n = NW'(MAX_CITIES);
    end else if (count_q < COUNT_W'(3)) begin
      n = NW'(3);
    end else begin
      n = NW'(count_q);
    end
  end

  assign load_ok = int'(city_index_i) < MAX_CITIES;
  assign pa_ext  = PCW'(first_pos_i);
  assign pb_ext  = PCW'(second_pos_i);
  assign n_ext   = PCW'(n);
  assign pa_in   = AW'(first_pos_i);
  assign pb_in   = AW'(second_pos_i);
  assign lo_in   = (pa_in < pb_in) ? pa_in : pb_in;
  assign hi_in   = (pa_in < pb_in) ? pb_in : pa_in;

  // Source position of the proposed tour entry at the swept position.
  always_comb begin
    iw  = AW'(cnt_q);
    src = iw;
    j   = iw - AW'(2);
    if (!bad_q && iw < AW'(n)) begin
      case (kind_q)
        MV_SWAP: begin
          if (iw == pa_q) begin
            src = pb_q;
          end else if (iw == pb_q) begin
            src = pa_q;
          end
        end
        MV_REVERSE: begin
          if (iw >= lo_q && iw <= hi_q) begin
            src = lo_q + hi_q - iw;
          end
        end
        MV_FRONT: begin
          if (iw == AW'(0)) begin
            src = pa_q;
          end else if (iw == AW'(1)) begin
            src = pb_q;
          end else begin
            // Skip the two entries that went to the front.
            if (j >= lo_q) j = j + AW'(1);
            if (j >= hi_q) j = j + AW'(1);
            src = j;
          end
        end
        MV_ROTATE: begin
          if (iw < rot_a_q) begin
            src = hi_q + iw;
          end else if (iw < rot_b_q) begin
            src = iw - rot_a_q + lo_q + AW'(1);
          end else begin
            src = iw - rot_b_q;
          end
        end
        default: src = iw;
      endcase
    end
  end

  // Port A reads the current tour in order (or the read request), port B the moved source.
  assign tour_ra = (state_q == S_SWEEP) ? {cur_q, IW'(cnt_q)} : {cur_q, IW'(city_index_i)};
  assign tour_rb = {cur_q, IW'(src)};

  always_comb begin
    if (state_q == S_INIT) begin
      tour_we = 1'b1;
      tour_wa = {1'b0, IW'(cnt_q)};
      tour_wd = IW'(cnt_q);
    end else begin
      tour_we = s1_vld_q && !s1_last_q;
      tour_wa = {!cur_q, IW'(s1_i_q)};
      tour_wd = tour_rd_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tour_we) tour_mem[tour_wa] <= tour_wd;
    tour_rd_a_q <= tour_mem[tour_ra];
    tour_rd_b_q <= tour_mem[tour_rb];
  end

  assign load_we = in_acc && (mode_i == MODE_LOAD) && load_ok;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      x_mem[IW'(city_index_i)] <= COORD_BITS'(coord_x_i);
      y_mem[IW'(city_index_i)] <= COORD_BITS'(coord_y_i);
    end
    xa_q <= x_mem[tour_rd_a_q];
    ya_q <= y_mem[tour_rd_a_q];
    xb_q <= x_mem[tour_rd_b_q];
    yb_q <= y_mem[tour_rd_b_q];
  end

  // The closing edge is handled as one extra position that reuses the first city.
  always_comb begin
    if (s2_i_q == n) begin
      cur_ox = first_ox_q;
      cur_oy = first_oy_q;
      cur_nx = first_nx_q;
      cur_ny = first_ny_q;
    end else begin
      cur_ox = xa_q;
      cur_oy = ya_q;
      cur_nx = xb_q;
      cur_ny = yb_q;
    end
  end

  assign edge_vld = s2_vld_q && (s2_i_q != '0) && (s2_i_q <= n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      s3_tag_q  <= '0;
      s4_tag_q  <= '0;
      s5_tag_q  <= '0;
    end else begin
      s1_vld_q  <= (state_q == S_SWEEP);
      s1_last_q <= (state_q == S_SWEEP) && (cnt_q == NW'(MAX_CITIES));
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_vld_q && s1_last_q;
      s3_tag_q  <= {s2_vld_q && s2_last_q, edge_vld};
      s4_tag_q  <= s3_tag_q;
      s5_tag_q  <= s4_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_i_q <= cnt_q;
    s2_i_q <= s1_i_q;
    if (s2_vld_q) begin
      prev_ox_q <= cur_ox;
      prev_oy_q <= cur_oy;
      prev_nx_q <= cur_nx;
      prev_ny_q <= cur_ny;
      if (s2_i_q == '0) begin
        first_ox_q <= xa_q;
        first_oy_q <= ya_q;
        first_nx_q <= xb_q;
        first_ny_q <= yb_q;
      end
    end
    dxo_q <= abs_diff(prev_ox_q, cur_ox);
    dyo_q <= abs_diff(prev_oy_q, cur_oy);
    dxn_q <= abs_diff(prev_nx_q, cur_nx);
    dyn_q <= abs_diff(prev_ny_q, cur_ny);
    sxo_q <= SQ_W'(dxo_q) * SQ_W'(dxo_q);
    syo_q <= SQ_W'(dyo_q) * SQ_W'(dyo_q);
    sxn_q <= SQ_W'(dxn_q) * SQ_W'(dxn_q);
    syn_q <= SQ_W'(dyn_q) * SQ_W'(dyn_q);
    s5_val_q[0] <= VAL_W'(sxo_q) + VAL_W'(syo_q);
    s5_val_q[1] <= VAL_W'(sxn_q) + VAL_W'(syn_q);
  end

  tspam_root #(
    .VAL_W (VAL_W)
  ) u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s5_tag_q),
    .val_i  (s5_val_q),
    .tag_o  (root_tag),
    .root_o (root_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      count_q <= cfg_data;
    end
  end

  assign take_out = !out_valid_q || !out_stall;
  assign keep     = !bad_q && (CMP_W'(sum_new_q) < CMP_W'(sum_old_q) + CMP_W'(margin_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      cur_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      kind_q       <= MV_SWAP;
      bad_q        <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      // A result word moving out of the staging registers refills the output instead.
      if (out_valid_q && !out_stall && state_q != S_RESULT) out_valid_q <= 1'b0;
      if (root_tag[0]) begin
        sum_old_q <= sum_old_q + SUM_W'(root_val[0]);
        sum_new_q <= sum_new_q + SUM_W'(root_val[1]);
      end
      case (state_q)
        S_INIT: begin
          if (cnt_q == NW'(MAX_CITIES - 1)) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + NW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_old_q    <= '0;
            res_new_q    <= '0;
            res_acc_q    <= 1'b0;
            res_entry_q  <= '0;
            case (mode_i)
              MODE_LOAD: begin
                res_status_q <= load_ok ? ST_OK : ST_BAD_INDEX;
                state_q      <= S_RESULT;
              end
              MODE_MOVE: begin
                res_status_q <= ST_OK;
                kind_q    <= move_e'(move_kind_i);
                pa_q      <= pa_in;
                pb_q      <= pb_in;
                lo_q      <= lo_in;
                hi_q      <= hi_in;
                rot_a_q   <= AW'(n) - hi_in;
                rot_b_q   <= AW'(n) - lo_in - AW'(1);
                bad_q     <= (pa_ext == pb_ext) || (pa_ext >= n_ext) || (pb_ext >= n_ext);
                margin_q  <= accept_margin_i;
                sum_old_q <= '0;
                sum_new_q <= '0;
                cnt_q     <= '0;
                state_q   <= S_SWEEP;
              end
              MODE_READ: begin
                res_status_q <= ST_OK;
                idx_ok_q     <= PCW'(city_index_i) < n_ext;
                state_q      <= S_READ;
              end
              default: begin
                res_status_q <= ST_BAD_INDEX;
                state_q      <= S_RESULT;
              end
            endcase
          end
        end
        S_SWEEP: begin
          cnt_q <= cnt_q + NW'(1);
          if (cnt_q == NW'(MAX_CITIES)) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (root_tag[1]) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          // A kept move just points at the bank that holds the rebuilt tour.
          res_old_q    <= saturate(sum_old_q);
          res_new_q    <= saturate(sum_new_q);
          res_acc_q    <= keep;
          res_status_q <= bad_q ? ST_BAD_POS : ST_OK;
          if (keep) cur_q <= !cur_q;
          state_q <= S_RESULT;
        end
        S_READ: begin
          if (idx_ok_q) begin
            res_entry_q <= POS_W'(tour_rd_a_q);
          end else begin
            res_status_q <= ST_BAD_INDEX;
          end
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (take_out) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESULT && take_out) begin
      out_old_q    <= res_old_q;
      out_new_q    <= res_new_q;
      out_acc_q    <= res_acc_q;
      out_status_q <= res_status_q;
      out_entry_q  <= res_entry_q;
    end
  end

  assign out_valid    = out_valid_q;
  assign old_length_o = out_old_q;
  assign new_length_o = out_new_q;
  assign accepted_o   = out_acc_q;
  assign status_o     = out_status_q;
  assign tour_entry_o = out_entry_q;

endmodule

FILE: rtl/tspam_root.sv
module tspam_root import tspam_pkg::*; #(
  parameter int VAL_W = 2 * COORD_BITS_DEF + 1,
  localparam int RW = (VAL_W + 17) / 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [TAG_W-1:0]                 tag_i,
  input  logic [LANES-1:0][VAL_W-1:0]      val_i,
  output logic [TAG_W-1:0]                 tag_o,
  output logic [LANES-1:0][RW-1:0]         root_o
);

  // One result bit per stage; the input is scaled by 2^16 so the root has 8 fraction bits.
  localparam int PAD_W = 2 * RW;
  localparam int REM_W = RW + 3;

  logic [TAG_W-1:0]                tag_q  [RW];
  logic [LANES-1:0][PAD_W-1:0]     val_q  [RW];
  logic [LANES-1:0][REM_W-1:0]     rem_q  [RW];
  logic [LANES-1:0][RW-1:0]        root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [TAG_W-1:0]            tag_in;
    logic [LANES-1:0][PAD_W-1:0] val_in, val_d;
    logic [LANES-1:0][REM_W-1:0] rem_in, rem_d;
    logic [LANES-1:0][RW-1:0]    root_in, root_d;

    if (k == 0) begin : g_first
      assign tag_in  = tag_i;
      assign rem_in  = '0;
      assign root_in = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_pad
        assign val_in[l] = PAD_W'({val_i[l], 16'b0});
      end
    end else begin : g_next
      assign tag_in  = tag_q[k-1];
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        shifted = {rem_in[l][REM_W-3:0], val_in[l][PAD_W-1 -: 2]};
        trial   = REM_W'({root_in[l], 2'b01});
        val_d[l] = val_in[l] << 2;
        if (shifted >= trial) begin
          rem_d[l]  = shifted - trial;
          root_d[l] = {root_in[l][RW-2:0], 1'b1};
        end else begin
          rem_d[l]  = shifted;
          root_d[l] = {root_in[l][RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else begin
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[k]  <= val_d;
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
    end
  end

  assign tag_o  = tag_q[RW-1];
  assign root_o = root_q[RW-1];

endmodule
